// ===== rtl/core/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// csvt_pkg
// Types and constants shared by the CSV column tagger modules.
// ----------------------------------------------------------------------------
package csvt_pkg;

   localparam int unsigned NUM_COLUMN_STYLES_DEFAULT = 10;
   localparam int unsigned ROW_GROUP_DEFAULT         = 100;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned QUOTE_W  = 7;
   localparam int unsigned STYLE_W  = 4;
   localparam int unsigned ROW_W    = 7;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [BYTE_W-1:0] CHAR_EQUALS    = 8'h3D;
   localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [BYTE_W-1:0] CHAR_BLANK     = 8'h20;

   localparam logic [BYTE_W-1:0]  DELIMITER_RESET = 8'd44;
   localparam logic [QUOTE_W-1:0] QUOTE_RESET     = 7'd34;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELIMITER_CHAR   = 3'd0,
      CSR_QUOTE_CHAR       = 3'd1,
      CSR_BACKSLASH_ESCAPE = 3'd2,
      CSR_MERGE_DELIMITERS = 3'd3,
      CSR_FOLD_ENABLE      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  delimiter_char;
      logic [QUOTE_W-1:0] quote_char;
      logic               backslash_escape;
      logic               merge_delimiters;
      logic               fold_enable;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              is_lead_byte;
      logic              line_end;
   } item_type;

   typedef struct packed {
      logic [STYLE_W-1:0] style_index;
      logic               fold_valid;
      logic               fold_header;
      logic               quote_continues;
   } result_type;

endpackage

// ===== rtl/core/csv_field_column_tagger_core.sv =====
// ----------------------------------------------------------------------------
// csv_field_column_tagger_core
// Tags each CSV byte with its column style and reports fold levels at line end.
// ----------------------------------------------------------------------------
// Path: an accepted req is held in the input register, then its tag is written to
// the result register, which drives rsp_tvalid and rsp_tdata.
// Throughput: 1 item per cycle while rsp_tready does not stall the result register;
// the whole state update is one pass of compare logic between the input register and the result register.
// Reset: synchronous, active high; clears parser state and loads register defaults.
// No clearing pass; req_tready is high from the first clock edge of reset on.
module csv_field_column_tagger_core
   import csvt_pkg::*;
#(
   parameter int unsigned NUM_COLUMN_STYLES = NUM_COLUMN_STYLES_DEFAULT,
   parameter int unsigned ROW_GROUP         = ROW_GROUP_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,  // [7:0] data_byte
   input  logic                 req_tuser,  // [0] is_lead_byte
   input  logic                 req_tlast,  // line_end
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,  // [3:0] style_index, [4] fold_valid,
                                            // [5] fold_header, [6] quote_continues
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type result, result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_advance;
   logic       item_advance;

   assign csr_ready = 1'b1;

   csvt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   assign rsp_advance  = !rsp_valid_ff || rsp_tready;
   assign item_advance = item_valid_ff && rsp_advance;
   assign req_tready   = !item_valid_ff || rsp_advance;

   csvt_tagger #(
      .NUM_COLUMN_STYLES (NUM_COLUMN_STYLES),
      .ROW_GROUP         (ROW_GROUP)
   ) u_tagger (
      .clock  (clock),
      .reset  (reset),
      .step   (item_advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_advance) begin
         rsp_valid_in = item_valid_ff;
         result_in    = result;
      end
      if (req_tready) begin
         item_valid_in        = req_tvalid;
         item_in.data_byte    = req_tdata;
         item_in.is_lead_byte = req_tuser;
         item_in.line_end     = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff.quote_continues, result_ff.fold_header,
                        result_ff.fold_valid, result_ff.style_index};

   a_header_needs_fold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!result_ff.fold_header || result_ff.fold_valid))
      else $error("fold header reported without fold valid");

   a_reset_empty : assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_tvalid && req_tready))
      else $error("pipeline not empty after reset");

   a_item_moves : assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && rsp_advance) |=> rsp_tvalid)
      else $error("stepped item did not reach the result register");

   a_style_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (result_ff.style_index <= STYLE_W'(NUM_COLUMN_STYLES)))
      else $error("style index out of range");

endmodule

// ===== rtl/core/csvt_csr.sv =====
// ----------------------------------------------------------------------------
// csvt_csr
// Configuration registers of the CSV column tagger.
// ----------------------------------------------------------------------------
module csvt_csr
   import csvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [BYTE_W-1:0]    wr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_DELIMITER_CHAR:   cfg_in.delimiter_char   = wr_data;
            CSR_QUOTE_CHAR:       cfg_in.quote_char       = wr_data[QUOTE_W-1:0];
            CSR_BACKSLASH_ESCAPE: cfg_in.backslash_escape = wr_data[0];
            CSR_MERGE_DELIMITERS: cfg_in.merge_delimiters = wr_data[0];
            CSR_FOLD_ENABLE:      cfg_in.fold_enable      = wr_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter_char   <= DELIMITER_RESET;
         cfg_ff.quote_char       <= QUOTE_RESET;
         cfg_ff.backslash_escape <= 1'b0;
         cfg_ff.merge_delimiters <= 1'b0;
         cfg_ff.fold_enable      <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/csvt_tagger.sv =====
// ----------------------------------------------------------------------------
// csvt_tagger
// Parser state and the per-item update that tags one byte.
// ----------------------------------------------------------------------------
module csvt_tagger
   import csvt_pkg::*;
#(
   parameter int unsigned NUM_COLUMN_STYLES = NUM_COLUMN_STYLES_DEFAULT,
   parameter int unsigned ROW_GROUP         = ROW_GROUP_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   localparam logic [STYLE_W:0]   NUM_STYLES_W = (STYLE_W+1)'(NUM_COLUMN_STYLES);
   localparam logic [STYLE_W-1:0] DELIM_STYLE  = STYLE_W'(NUM_COLUMN_STYLES);
   localparam logic [ROW_W:0]     ROW_GROUP_W  = (ROW_W+1)'(ROW_GROUP);

   logic              in_quotes_ff, in_quotes_in;
   logic [STYLE_W-1:0] column_ff, column_in;
   logic [BYTE_W-1:0] prev_byte_ff, prev_byte_in;
   logic [BYTE_W-1:0] prev_nonblank_ff, prev_nonblank_in;
   logic              skip_next_ff, skip_next_in;
   logic              pend_close_ff, pend_close_in;
   logic              pend_equals_ff, pend_equals_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              first_line_ff, first_line_in;

   always_comb begin
      logic               consumed;
      logic               pend;
      logic               is_quote;
      logic [STYLE_W:0]   col_sum;
      logic [ROW_W:0]     row_sum;
      in_quotes_in     = in_quotes_ff;
      column_in        = column_ff;
      prev_byte_in     = prev_byte_ff;
      prev_nonblank_in = prev_nonblank_ff;
      skip_next_in     = skip_next_ff;
      pend_close_in    = pend_close_ff;
      pend_equals_in   = pend_equals_ff;
      row_in           = row_ff;
      first_line_in    = first_line_ff;
      result           = '0;
      result.style_index = column_ff;
      consumed = 1'b0;
      pend     = 1'b0;
      is_quote = (item.data_byte == {1'b0, cfg.quote_char});
      col_sum  = {1'b0, column_ff} + (STYLE_W+1)'(1);
      row_sum  = {1'b0, row_ff} + (ROW_W+1)'(1);

      priority if (skip_next_ff) begin
         skip_next_in = 1'b0;
         consumed     = 1'b1;
      end else if (pend_close_ff) begin
         pend_close_in = 1'b0;
         if (is_quote) begin
            consumed = 1'b1;
         end else begin
            in_quotes_in = 1'b0;
         end
      end else if (pend_equals_ff) begin
         pend_equals_in = 1'b0;
         if (is_quote) begin
            in_quotes_in = 1'b1;
            consumed     = 1'b1;
         end
      end else begin
         consumed = 1'b0;
      end

      if (!consumed) begin
         priority if (in_quotes_in) begin
            if (is_quote) begin
               pend_close_in = 1'b1;
               pend          = 1'b1;
            end
         end else if (item.data_byte == cfg.delimiter_char) begin
            result.style_index = DELIM_STYLE;
            prev_nonblank_in   = item.data_byte;
            if (item.data_byte != prev_byte_ff || !cfg.merge_delimiters) begin
               column_in = (col_sum >= NUM_STYLES_W) ? '0 : col_sum[STYLE_W-1:0];
            end
         end else if (prev_nonblank_ff == cfg.delimiter_char) begin
            if (is_quote) begin
               in_quotes_in = 1'b1;
            end else if (item.data_byte == CHAR_EQUALS) begin
               pend_equals_in = 1'b1;
               pend           = 1'b1;
            end
         end else begin
            pend = 1'b0;
         end
         prev_byte_in = item.data_byte;
         if (item.data_byte > CHAR_BLANK) begin
            prev_nonblank_in = item.data_byte;
            if (!pend) begin
               if ((item.data_byte == CHAR_BACKSLASH && cfg.backslash_escape)
                   || item.is_lead_byte) begin
                  skip_next_in = 1'b1;
               end
            end
         end
      end

      if (item.line_end) begin
         if (pend_close_in) begin
            in_quotes_in = 1'b0;
         end
         pend_close_in  = 1'b0;
         pend_equals_in = 1'b0;
         skip_next_in   = 1'b0;
         if (cfg.fold_enable) begin
            result.fold_valid = 1'b1;
            if (row_sum >= ROW_GROUP_W || first_line_ff) begin
               row_in             = '0;
               result.fold_header = 1'b1;
            end else begin
               row_in = row_sum[ROW_W-1:0];
            end
         end
         first_line_in    = 1'b0;
         prev_byte_in     = '0;
         prev_nonblank_in = cfg.delimiter_char;
         if (!in_quotes_in) begin
            column_in = '0;
         end
         result.quote_continues = in_quotes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff     <= 1'b0;
         column_ff        <= '0;
         prev_byte_ff     <= '0;
         prev_nonblank_ff <= DELIMITER_RESET;
         skip_next_ff     <= 1'b0;
         pend_close_ff    <= 1'b0;
         pend_equals_ff   <= 1'b0;
         row_ff           <= '0;
         first_line_ff    <= 1'b1;
      end else if (step) begin
         in_quotes_ff     <= in_quotes_in;
         column_ff        <= column_in;
         prev_byte_ff     <= prev_byte_in;
         prev_nonblank_ff <= prev_nonblank_in;
         skip_next_ff     <= skip_next_in;
         pend_close_ff    <= pend_close_in;
         pend_equals_ff   <= pend_equals_in;
         row_ff           <= row_in;
         first_line_ff    <= first_line_in;
      end
   end

endmodule
